### rtl/hcbp_pkg.sv
package hcbp_pkg;

    localparam int MAX_CODE_BITS_DEF = 32;
    localparam int SYMBOL_COUNT_DEF  = 256;

    localparam int BYTE_W      = 8;
    localparam int CODE_FLD_W  = 32;
    localparam int LEN_FLD_W   = 6;
    localparam int SYM_FLD_W   = 8;
    localparam int KIND_W      = 2;
    localparam int PEND_W      = BYTE_W - 1;
    localparam int PCNT_W      = 3;
    // pending bits plus one full code, left aligned
    localparam int STREAM_W    = PEND_W + CODE_FLD_W;

    // command queue between front and back; depth is a power of two
    localparam int QUEUE_DEPTH = 4;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
    localparam logic [KIND_W-1:0] KIND_ENCODE = 2'd1;
    localparam logic [KIND_W-1:0] KIND_FLUSH  = 2'd2;

    typedef enum logic [1:0] {
        OP_ENC,
        OP_ERR,
        OP_FLUSH
    } t_op;

    typedef struct packed {
        t_op                   op;
        logic [CODE_FLD_W-1:0] word;
        logic [LEN_FLD_W-1:0]  len;
    } t_cmd;

endpackage

### rtl/hcbp_ram.sv
module hcbp_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_addr,
    input  logic [WIDTH-1:0]         i_wdata,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_addr] <= i_wdata;
        end
        r_rdata <= r_mem[i_addr];
    end

    assign o_rdata = r_rdata;

endmodule

### rtl/hcbp_front.sv
module hcbp_front #(
    parameter int MAX_CODE_BITS = hcbp_pkg::MAX_CODE_BITS_DEF,
    parameter int SYMBOL_COUNT  = hcbp_pkg::SYMBOL_COUNT_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_valid,
    output logic                            o_ready,
    input  logic [hcbp_pkg::KIND_W-1:0]     i_kind,
    input  logic [hcbp_pkg::SYM_FLD_W-1:0]  i_symbol,
    input  logic [hcbp_pkg::CODE_FLD_W-1:0] i_code_bits,
    input  logic [hcbp_pkg::LEN_FLD_W-1:0]  i_code_length,
    input  logic [hcbp_pkg::QCNT_W-1:0]     i_q_count,
    output logic                            o_push,
    output hcbp_pkg::t_cmd                  o_cmd
);

    localparam int LIMIT  = (MAX_CODE_BITS < hcbp_pkg::CODE_FLD_W) ?
                            MAX_CODE_BITS : hcbp_pkg::CODE_FLD_W;
    localparam int CODE_W = LIMIT;
    localparam int LEN_W  = $clog2(LIMIT + 1);
    localparam int SYM_W  = $clog2(SYMBOL_COUNT);

    logic                                 acc;
    logic                                 in_range;
    logic [SYM_W-1:0]                     idx;
    logic [hcbp_pkg::LEN_FLD_W-1:0]       len_sat;
    logic                                 we;
    logic [hcbp_pkg::QCNT_W:0]            q_need;
    logic [CODE_W-1:0]                    rd_word;
    logic [LEN_W-1:0]                     rd_len;

    logic                                 r_s1_vld;
    hcbp_pkg::t_op                        r_s1_op;
    logic [SYMBOL_COUNT-1:0]              r_vld;

    // room for the item in the lookup stage and this one
    assign q_need   = {1'b0, i_q_count} + (hcbp_pkg::QCNT_W + 1)'(r_s1_vld);
    assign o_ready  = q_need < (hcbp_pkg::QCNT_W + 1)'(hcbp_pkg::QUEUE_DEPTH);
    assign acc      = i_valid && o_ready;
    assign in_range = {1'b0, i_symbol} < (hcbp_pkg::SYM_FLD_W + 1)'(SYMBOL_COUNT);
    assign idx      = i_symbol[SYM_W-1:0];
    assign len_sat  = (i_code_length > hcbp_pkg::LEN_FLD_W'(LIMIT)) ?
                      hcbp_pkg::LEN_FLD_W'(LIMIT) : i_code_length;
    assign we       = acc && (i_kind == hcbp_pkg::KIND_LOAD) && in_range;

    hcbp_ram #(
        .WIDTH (CODE_W),
        .DEPTH (SYMBOL_COUNT)
    ) u_word_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_addr  (idx),
        .i_wdata (i_code_bits[CODE_W-1:0]),
        .o_rdata (rd_word)
    );

    hcbp_ram #(
        .WIDTH (LEN_W),
        .DEPTH (SYMBOL_COUNT)
    ) u_len_ram (
        .i_clk   (i_clk),
        .i_we    (we),
        .i_addr  (idx),
        .i_wdata (len_sat[LEN_W-1:0]),
        .o_rdata (rd_len)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_s1_vld <= 1'b0;
            r_s1_op  <= hcbp_pkg::OP_ERR;
        end else begin
            if (we) begin
                r_vld[idx] <= 1'b1;
            end
            r_s1_vld <= 1'b0;
            if (acc) begin
                unique case (i_kind)
                    hcbp_pkg::KIND_ENCODE: begin
                        r_s1_vld <= 1'b1;
                        r_s1_op  <= (in_range && r_vld[idx]) ? hcbp_pkg::OP_ENC
                                                             : hcbp_pkg::OP_ERR;
                    end
                    hcbp_pkg::KIND_FLUSH: begin
                        r_s1_vld <= 1'b1;
                        r_s1_op  <= hcbp_pkg::OP_FLUSH;
                    end
                    default: begin
                        r_s1_vld <= 1'b0;
                    end
                endcase
            end
        end
    end

    // a loaded length of zero also marks the entry empty
    always_comb begin
        o_push    = r_s1_vld;
        o_cmd.op  = (r_s1_op == hcbp_pkg::OP_ENC && rd_len == '0) ? hcbp_pkg::OP_ERR
                                                                  : r_s1_op;
        o_cmd.word = hcbp_pkg::CODE_FLD_W'(rd_word);
        o_cmd.len  = hcbp_pkg::LEN_FLD_W'(rd_len);
    end

endmodule

### rtl/hcbp_queue.sv
module hcbp_queue (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_push,
    input  hcbp_pkg::t_cmd              i_cmd,
    input  logic                        i_pop,
    output logic                        o_valid,
    output hcbp_pkg::t_cmd              o_cmd,
    output logic [hcbp_pkg::QCNT_W-1:0] o_count
);

    hcbp_pkg::t_cmd                r_mem [hcbp_pkg::QUEUE_DEPTH];
    logic [hcbp_pkg::QPTR_W-1:0]   r_wp;
    logic [hcbp_pkg::QPTR_W-1:0]   r_rp;
    logic [hcbp_pkg::QCNT_W-1:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
        end else begin
            if (i_push) begin
                r_wp <= r_wp + 1'b1;
            end
            if (i_pop) begin
                r_rp <= r_rp + 1'b1;
            end
            r_cnt <= r_cnt + hcbp_pkg::QCNT_W'(i_push) - hcbp_pkg::QCNT_W'(i_pop);
        end
    end

    assign o_valid = r_cnt != '0;
    assign o_cmd   = r_mem[r_rp];
    assign o_count = r_cnt;

endmodule

### rtl/hcbp_back.sv
module hcbp_back (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_cmd_vld,
    input  hcbp_pkg::t_cmd              i_cmd,
    output logic                        o_pop,
    output logic                        o_valid,
    input  logic                        i_ready,
    output logic [hcbp_pkg::BYTE_W-1:0] o_byte,
    output logic                        o_status,
    output logic                        o_last
);

    localparam int SW = hcbp_pkg::STREAM_W;

    typedef enum logic {
        S_IDLE,
        S_EMIT
    } t_state;

    t_state                          r_state, n_state;
    logic [SW-1:0]                   r_sh, n_sh;
    logic [hcbp_pkg::LEN_FLD_W-1:0]  r_tot, n_tot;
    logic [hcbp_pkg::PEND_W-1:0]     r_pend, n_pend;
    logic [hcbp_pkg::PCNT_W-1:0]     r_pcnt, n_pcnt;
    logic                            r_ovld, n_ovld;
    logic [hcbp_pkg::BYTE_W-1:0]     r_obyte, n_obyte;
    logic                            r_ostat, n_ostat;
    logic                            r_olast, n_olast;
    logic                            n_pop;

    logic                            out_free;
    logic [hcbp_pkg::CODE_FLD_W-1:0] code_al;
    logic [SW-1:0]                   stream;
    logic [hcbp_pkg::LEN_FLD_W-1:0]  total;

    assign out_free = !r_ovld || i_ready;
    // code left aligned, then placed behind the pending bits
    assign code_al  = i_cmd.word << (hcbp_pkg::LEN_FLD_W'(hcbp_pkg::CODE_FLD_W) - i_cmd.len);
    assign stream   = {r_pend, hcbp_pkg::CODE_FLD_W'(0)}
                    | ({code_al, hcbp_pkg::PEND_W'(0)} >> r_pcnt);
    assign total    = hcbp_pkg::LEN_FLD_W'(r_pcnt) + i_cmd.len;

    always_comb begin
        n_state = r_state;
        n_sh    = r_sh;
        n_tot   = r_tot;
        n_pend  = r_pend;
        n_pcnt  = r_pcnt;
        n_ovld  = r_ovld && !i_ready;
        n_obyte = r_obyte;
        n_ostat = r_ostat;
        n_olast = r_olast;
        n_pop   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_cmd_vld) begin
                    unique case (i_cmd.op)
                        hcbp_pkg::OP_ERR: begin
                            if (out_free) begin
                                n_ovld  = 1'b1;
                                n_obyte = '0;
                                n_ostat = 1'b1;
                                n_olast = 1'b1;
                                n_pop   = 1'b1;
                            end
                        end
                        hcbp_pkg::OP_FLUSH: begin
                            if (r_pcnt == '0) begin
                                n_pop = 1'b1;
                            end else if (out_free) begin
                                n_ovld  = 1'b1;
                                n_obyte = {r_pend, 1'b0};
                                n_ostat = 1'b0;
                                n_olast = 1'b1;
                                n_pend  = '0;
                                n_pcnt  = '0;
                                n_pop   = 1'b1;
                            end
                        end
                        hcbp_pkg::OP_ENC: begin
                            n_sh    = stream;
                            n_tot   = total;
                            n_pop   = 1'b1;
                            n_state = S_EMIT;
                        end
                        default: begin
                            n_pop = 1'b1;
                        end
                    endcase
                end
            end
            S_EMIT: begin
                if (r_tot >= hcbp_pkg::LEN_FLD_W'(hcbp_pkg::BYTE_W)) begin
                    if (out_free) begin
                        n_ovld  = 1'b1;
                        n_obyte = r_sh[SW-1 -: hcbp_pkg::BYTE_W];
                        n_ostat = 1'b0;
                        n_olast = r_tot < hcbp_pkg::LEN_FLD_W'(2 * hcbp_pkg::BYTE_W);
                        n_sh    = {r_sh[SW-hcbp_pkg::BYTE_W-1:0], hcbp_pkg::BYTE_W'(0)};
                        n_tot   = r_tot - hcbp_pkg::LEN_FLD_W'(hcbp_pkg::BYTE_W);
                    end
                end else begin
                    // leftover bits stay left aligned, zeros below them
                    n_pend  = r_sh[SW-1 -: hcbp_pkg::PEND_W];
                    n_pcnt  = r_tot[hcbp_pkg::PCNT_W-1:0];
                    n_state = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_pend  <= '0;
            r_pcnt  <= '0;
            r_ovld  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_pend  <= n_pend;
            r_pcnt  <= n_pcnt;
            r_ovld  <= n_ovld;
        end
        r_sh    <= n_sh;
        r_tot   <= n_tot;
        r_obyte <= n_obyte;
        r_ostat <= n_ostat;
        r_olast <= n_olast;
    end

    assign o_pop    = n_pop;
    assign o_valid  = r_ovld;
    assign o_byte   = r_obyte;
    assign o_status = r_ostat;
    assign o_last   = r_olast;

endmodule

### rtl/huffman_code_bit_packer.sv
// Huffman code packer. Each input word is a table load, an encode or a flush, chosen by
// s_axis_tuser. A load writes one code-table entry and gives no output; table entries are
// marked empty after reset, so no clearing time is needed. An encode looks the symbol up
// in the front lookup stage, then the packer aligns the code behind the buffered bits,
// sends each finished byte, up to four, as the output takes it, and keeps the leftover
// bits. A flush sends any buffered bits as one final byte, and an error result sends one
// zero byte with m_axis_tuser set. A four-entry command queue sits between lookup and
// packer, so loads and lookups keep flowing while the output side stalls, until the queue
// fills. Bytes go out MSB first; m_axis_tuser set marks a symbol with no code, and
// m_axis_tlast marks the final byte caused by one input word.
module huffman_code_bit_packer #(
    parameter int MAX_CODE_BITS = hcbp_pkg::MAX_CODE_BITS_DEF,
    parameter int SYMBOL_COUNT  = hcbp_pkg::SYMBOL_COUNT_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [47:0] s_axis_tdata,  // symbol[7:0], code_bits[39:8], code_length[45:40]
    input  logic [1:0]  s_axis_tuser,  // kind[1:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    output logic [7:0]  m_axis_tdata,  // out_byte[7:0]
    output logic        m_axis_tuser,  // status[0]
    output logic        m_axis_tlast
);

    logic                        push;
    hcbp_pkg::t_cmd              push_cmd;
    logic                        pop;
    logic                        q_vld;
    hcbp_pkg::t_cmd              q_cmd;
    logic [hcbp_pkg::QCNT_W-1:0] q_count;

    hcbp_front #(
        .MAX_CODE_BITS (MAX_CODE_BITS),
        .SYMBOL_COUNT  (SYMBOL_COUNT)
    ) u_front (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_valid       (s_axis_tvalid),
        .o_ready       (s_axis_tready),
        .i_kind        (s_axis_tuser),
        .i_symbol      (s_axis_tdata[7:0]),
        .i_code_bits   (s_axis_tdata[39:8]),
        .i_code_length (s_axis_tdata[45:40]),
        .i_q_count     (q_count),
        .o_push        (push),
        .o_cmd         (push_cmd)
    );

    hcbp_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (push_cmd),
        .i_pop   (pop),
        .o_valid (q_vld),
        .o_cmd   (q_cmd),
        .o_count (q_count)
    );

    hcbp_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_cmd_vld (q_vld),
        .i_cmd     (q_cmd),
        .o_pop     (pop),
        .o_valid   (m_axis_tvalid),
        .i_ready   (m_axis_tready),
        .o_byte    (m_axis_tdata),
        .o_status  (m_axis_tuser),
        .o_last    (m_axis_tlast)
    );

endmodule
